// ===== src/cdlf_pkg.sv =====
// Shared types and constants of the clock drift fit block.
// Used by the window walker, the solver, the divider and the top level.
package cdlf_pkg;

  // Field widths
  localparam int TickW   = 32;
  localparam int RefW    = 48;
  localparam int WrapW   = 16;
  localparam int ExtW    = 48;
  localparam int DiffW   = 64;
  localparam int ResW    = 64;

  // Per-entry deltas relative to the newest sample
  localparam int XW      = 49;
  localparam int YW      = 50;

  // Limb arithmetic: sums are four 32-bit limbs, products accumulate in six
  localparam int LimbW   = 32;
  localparam int SumLimbs = 4;
  localparam int SumW    = LimbW * SumLimbs;
  localparam int AccW    = 192;
  localparam int DenW    = 128;

  // Fixed-point fraction bits of the results
  localparam int SlopeFrac  = 40;
  localparam int OffsetFrac = 16;

  // Fewest samples that give a fit
  localparam int MinSamples = 3;

  // Window sums handed from the walker to the solver
  typedef struct packed {
    logic signed [SumW-1:0] sx;
    logic signed [SumW-1:0] sy;
    logic signed [SumW-1:0] sxx;
    logic signed [SumW-1:0] sxy;
  } sums_t;

  // Fit result
  typedef struct packed {
    logic signed [ResW-1:0] slope;
    logic signed [ResW-1:0] offset;
    logic                   valid;
  } fit_t;

  // Saturate a wide signed value to the result range
  function automatic logic signed [ResW-1:0] sat_res(input logic signed [AccW-1:0] v);
    logic [AccW-ResW:0] top;
    top = v[AccW-1:ResW-1];
    if ((&top) || !(|top)) begin
      sat_res = v[ResW-1:0];
    end else if (v[AccW-1]) begin
      sat_res = {1'b1, {(ResW-1){1'b0}}};
    end else begin
      sat_res = {1'b0, {(ResW-1){1'b1}}};
    end
  endfunction

endpackage

// ===== src/cdlf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module cdlf_ram #(
  parameter int Width = 64,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cdlf_window.sv =====
// Window walker: reads every filled entry of the sample stores and builds
// the sums Sx, Sy, Sxx and Sxy relative to the newest sample. Uses cdlf_pkg.
module cdlf_window #(
  parameter int DEPTH = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [$clog2(DEPTH+1)-1:0]        count_i,
  input  logic [cdlf_pkg::ExtW-1:0]         ext_i,
  input  logic signed [cdlf_pkg::DiffW-1:0] anchor_diff_i,
  output logic                              rd_en_o,
  output logic [$clog2(DEPTH)-1:0]          rd_addr_o,
  input  logic [cdlf_pkg::ExtW-1:0]         rd_tick_i,
  input  logic [cdlf_pkg::DiffW-1:0]        rd_diff_i,
  output logic                              done_o,
  output cdlf_pkg::sums_t                   sums_o
);
  import cdlf_pkg::*;

  localparam int CntW = $clog2(DEPTH+1);
  localparam int AW   = $clog2(DEPTH);
  localparam int PW   = 2 * (LimbW + 1);

  typedef enum logic [3:0] {
    W_IDLE  = 4'b0001,
    W_LOAD  = 4'b0010,
    W_MAC   = 4'b0100,
    W_FLUSH = 4'b1000
  } wstate_e;

  wstate_e                 state_q, state_d;
  logic [CntW-1:0]         idx_q;
  logic [1:0]              phase_q;
  logic                    pend_q;
  logic                    done_q;
  logic signed [XW-1:0]    x_q;
  logic signed [YW-1:0]    y_q;
  logic signed [XW-1:0]    x_d;
  logic signed [YW-1:0]    y_d;
  logic signed [DiffW-1:0] y_full;
  logic signed [LimbW:0]   x_lo, x_hi, y_lo, y_hi, xa, xb, yb;
  logic signed [PW-1:0]    pxx_q, pxy_q;
  logic [1:0]              psh_q;
  logic                    pv_q;
  logic signed [SumW-1:0]  sx_q, sy_q, sxx_q, sxy_q;
  logic signed [SumW-1:0]  txx, txy;
  logic                    issue;
  logic                    load_xy;

  // Deltas of the entry on the read port
  assign x_d    = $signed({1'b0, rd_tick_i}) - $signed({1'b0, ext_i});
  assign y_full = $signed(rd_diff_i) - anchor_diff_i;
  assign y_d    = y_full[YW-1:0];

  // Split deltas into a low unsigned limb and a high signed limb
  assign x_lo = $signed({1'b0, x_q[LimbW-1:0]});
  assign x_hi = $signed({{(2*LimbW+1-XW){x_q[XW-1]}}, x_q[XW-1:LimbW]});
  assign y_lo = $signed({1'b0, y_q[LimbW-1:0]});
  assign y_hi = $signed({{(2*LimbW+1-YW){y_q[YW-1]}}, y_q[YW-1:LimbW]});
  assign xa   = phase_q[1] ? x_hi : x_lo;
  assign xb   = phase_q[0] ? x_hi : x_lo;
  assign yb   = phase_q[0] ? y_hi : y_lo;

  // Read issue: first entry on start, then the next entry at phase zero of each limb round
  assign issue   = (state_q == W_MAC) && (phase_q == 2'd0) && (idx_q < count_i);
  assign rd_en_o = ((state_q == W_IDLE) && start_i) || issue;
  assign rd_addr_o = (state_q == W_IDLE) ? '0 : idx_q[AW-1:0];
  assign load_xy = (state_q == W_LOAD) || ((state_q == W_MAC) && (phase_q == 2'd3) && pend_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      W_IDLE:  if (start_i) state_d = W_LOAD;
      W_LOAD:  state_d = W_MAC;
      W_MAC:   if (phase_q == 2'd3 && !pend_q) state_d = W_FLUSH;
      W_FLUSH: state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      idx_q   <= '0;
      phase_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == W_FLUSH);
      pv_q    <= (state_q == W_MAC);
      if (state_q == W_IDLE && start_i) begin
        idx_q <= CntW'(1);
      end else if (issue) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (state_q == W_MAC) begin
        phase_q <= phase_q + 2'd1;
        if (phase_q == 2'd0) begin
          pend_q <= issue;
        end
      end else begin
        phase_q <= '0;
      end
    end
  end

  // Delta registers and limb products
  always_ff @(posedge clk_i) begin
    if (load_xy) begin
      x_q <= x_d;
      y_q <= y_d;
    end
    pxx_q <= xa * xb;
    pxy_q <= xa * yb;
    psh_q <= {1'b0, phase_q[1]} + {1'b0, phase_q[0]};
  end

  // Align a product to its limb position
  always_comb begin
    unique case (psh_q)
      2'd0:    begin txx = SumW'(pxx_q);               txy = SumW'(pxy_q);               end
      2'd1:    begin txx = SumW'(pxx_q) <<< LimbW;     txy = SumW'(pxy_q) <<< LimbW;     end
      2'd2:    begin txx = SumW'(pxx_q) <<< (2*LimbW); txy = SumW'(pxy_q) <<< (2*LimbW); end
      default: begin txx = '0;                         txy = '0;                         end
    endcase
  end

  // Accumulate sums
  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && start_i) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
    end else begin
      if (state_q == W_MAC && phase_q == 2'd0) begin
        sx_q <= sx_q + SumW'(x_q);
        sy_q <= sy_q + SumW'(y_q);
      end
      if (pv_q) begin
        sxx_q <= sxx_q + txx;
        sxy_q <= sxy_q + txy;
      end
    end
  end

  assign done_o     = done_q;
  assign sums_o.sx  = sx_q;
  assign sums_o.sy  = sy_q;
  assign sums_o.sxx = sxx_q;
  assign sums_o.sxy = sxy_q;

endmodule

// ===== src/cdlf_divider.sv =====
// Bit-serial restoring divider: signed numerator by positive denominator,
// quotient truncated toward zero, one quotient bit per cycle. Uses cdlf_pkg.
module cdlf_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [cdlf_pkg::AccW-1:0] numer_i,
  input  logic [cdlf_pkg::DenW-1:0]        denom_i,
  output logic                             done_o,
  output logic signed [cdlf_pkg::AccW-1:0] quot_o
);
  import cdlf_pkg::*;

  localparam int CW = $clog2(AccW);

  logic              run_q, done_q, neg_q;
  logic [CW-1:0]     cnt_q;
  logic [AccW-1:0]   mag_q, quo_q;
  logic [DenW:0]     rem_q;
  logic [DenW-1:0]   den_q;
  logic [DenW:0]     rem_sh;
  logic [DenW+1:0]   trial;
  logic              ge;

  // One restoring step
  assign rem_sh = {rem_q[DenW-1:0], mag_q[AccW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = !trial[DenW+1];

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(AccW-1);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) run_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= numer_i[AccW-1];
      mag_q <= numer_i[AccW-1] ? -numer_i : numer_i;
      quo_q <= '0;
      rem_q <= '0;
      den_q <= denom_i;
    end else if (run_q) begin
      rem_q <= ge ? trial[DenW:0] : rem_sh;
      quo_q <= {quo_q[AccW-2:0], ge};
      mag_q <= {mag_q[AccW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ===== src/cdlf_solver.sv =====
// Fit solver: forms the denominator and both numerators from the window sums
// with one shared limb multiplier, then divides them. Uses cdlf_pkg, cdlf_divider.
module cdlf_solver #(
  parameter int DEPTH = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [$clog2(DEPTH+1)-1:0]        count_i,
  input  cdlf_pkg::sums_t                   sums_i,
  input  logic signed [cdlf_pkg::DiffW-1:0] anchor_diff_i,
  output logic                              done_o,
  output cdlf_pkg::fit_t                    fit_o
);
  import cdlf_pkg::*;

  localparam int PW = 2 * (LimbW + 1);

  typedef enum logic [2:0] {
    OP_N_SXX  = 3'd0,
    OP_SX_SX  = 3'd1,
    OP_N_SXY  = 3'd2,
    OP_SX_SY  = 3'd3,
    OP_SY_SXX = 3'd4,
    OP_SX_SXY = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAC  = 4'b0010,
    S_DIVS = 4'b0100,
    S_DIVI = 4'b1000
  } sstate_e;

  typedef struct packed {
    logic       vld;
    logic       clr;
    logic       sub;
    logic       fin;
    logic [2:0] shf;
    op_e        op;
  } tag_t;

  sstate_e                state_q;
  logic                   iss_q;
  op_e                    op_q;
  logic [1:0]             li_q, lj_q;
  logic [SumW-1:0]        opa, opb;
  logic signed [LimbW:0]  la, lb;
  logic signed [PW-1:0]   prod_q;
  tag_t                   tag_q;
  logic signed [AccW-1:0] acc_q, acc_d, acc_base, term;
  logic [DenW-1:0]        den_q;
  logic                   den_pos_q;
  logic signed [AccW-1:0] nums_q, numi_q;
  logic                   div_go_q, div_done;
  logic signed [AccW-1:0] div_numer, div_quot, off_sum;
  logic                   done_q;
  fit_t                   fit_q;

  function automatic logic signed [LimbW:0] limb_of(input logic [SumW-1:0] v,
                                                     input logic [1:0] k);
    logic [LimbW-1:0] w;
    w = v[LimbW*k +: LimbW];
    limb_of = (k == 2'(SumLimbs-1)) ? $signed({v[SumW-1], w}) : $signed({1'b0, w});
  endfunction

  // Operand pair of the current product
  always_comb begin
    unique case (op_q)
      OP_N_SXX:  begin opa = SumW'(count_i); opb = sums_i.sxx; end
      OP_SX_SX:  begin opa = sums_i.sx;      opb = sums_i.sx;  end
      OP_N_SXY:  begin opa = SumW'(count_i); opb = sums_i.sxy; end
      OP_SX_SY:  begin opa = sums_i.sx;      opb = sums_i.sy;  end
      OP_SY_SXX: begin opa = sums_i.sy;      opb = sums_i.sxx; end
      OP_SX_SXY: begin opa = sums_i.sx;      opb = sums_i.sxy; end
      default:   begin opa = '0;             opb = '0;         end
    endcase
  end

  assign la = limb_of(opa, li_q);
  assign lb = limb_of(opb, lj_q);

  // Issue limb products and register them with their tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= 1'b0;
      op_q  <= OP_N_SXX;
      li_q  <= '0;
      lj_q  <= '0;
      tag_q <= '0;
    end else begin
      tag_q.vld <= iss_q;
      tag_q.clr <= (li_q == 2'd0) && (lj_q == 2'd0) && !op_q[0];
      tag_q.sub <= op_q[0];
      tag_q.fin <= (li_q == 2'd3) && (lj_q == 2'd3);
      tag_q.shf <= {1'b0, li_q} + {1'b0, lj_q};
      tag_q.op  <= op_q;
      if (state_q == S_IDLE && start_i) begin
        iss_q <= 1'b1;
        op_q  <= OP_N_SXX;
        li_q  <= '0;
        lj_q  <= '0;
      end else if (iss_q) begin
        lj_q <= lj_q + 2'd1;
        if (lj_q == 2'd3) begin
          li_q <= li_q + 2'd1;
          if (li_q == 2'd3) begin
            if (op_q == OP_SX_SXY) iss_q <= 1'b0;
            else op_q <= op_e'(op_q + 3'd1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= la * lb;
  end

  // Align product and accumulate
  assign term     = AccW'(prod_q) <<< (LimbW * int'(tag_q.shf));
  assign acc_base = tag_q.clr ? '0 : acc_q;
  assign acc_d    = tag_q.sub ? acc_base - term : acc_base + term;

  // Division operands
  assign div_numer = (state_q == S_DIVS) ? (nums_q <<< SlopeFrac) : (numi_q <<< OffsetFrac);
  assign off_sum   = div_quot + (AccW'(anchor_diff_i) <<< OffsetFrac);

  cdlf_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .numer_i (div_numer),
    .denom_i (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      div_go_q  <= 1'b0;
      done_q    <= 1'b0;
      den_pos_q <= 1'b0;
    end else begin
      div_go_q <= 1'b0;
      done_q   <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) state_q <= S_MAC;
        S_MAC: begin
          if (tag_q.vld && tag_q.fin) begin
            if (tag_q.op == OP_SX_SX) begin
              den_pos_q <= !acc_d[AccW-1] && (acc_d != '0);
            end
            if (tag_q.op == OP_SX_SXY) begin
              if (den_pos_q) begin
                state_q  <= S_DIVS;
                div_go_q <= 1'b1;
              end else begin
                state_q <= S_IDLE;
                done_q  <= 1'b1;
              end
            end
          end
        end
        S_DIVS: if (div_done) begin
          state_q  <= S_DIVI;
          div_go_q <= 1'b1;
        end
        S_DIVI: if (div_done) begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Accumulator, stored terms and result
  always_ff @(posedge clk_i) begin
    if (tag_q.vld) begin
      acc_q <= acc_d;
      if (tag_q.fin) begin
        unique case (tag_q.op)
          OP_SX_SX:  den_q  <= acc_d[DenW-1:0];
          OP_SX_SY:  nums_q <= acc_d;
          OP_SX_SXY: numi_q <= acc_d;
          default:   ;
        endcase
      end
    end
    if (state_q == S_IDLE && start_i) begin
      fit_q <= '0;
    end
    if (state_q == S_DIVS && div_done) begin
      fit_q.slope <= sat_res(div_quot);
    end
    if (state_q == S_DIVI && div_done) begin
      fit_q.offset <= sat_res(off_sum);
      fit_q.valid  <= 1'b1;
    end
  end

  assign done_o = done_q;
  assign fit_o  = fit_q;

endmodule

// ===== src/clock_drift_linear_fit.sv =====
// Clock drift fit top level: tick extension, sample stores, sequencing and
// the output register. Uses cdlf_pkg, cdlf_ram, cdlf_window, cdlf_solver.
//
//  channel | valid / ready          | payload
//  --------+------------------------+----------------------------------------------
//  in      | in_valid_i / in_ready_o  | tick_value_i, reference_us_i
//  out     | out_valid_o / out_ready_i| fit_slope_o, fit_offset_o, anchor_tick_o,
//          |                        | fit_valid_o
//
// With n filled entries (n >= 3) a request runs from accept to a valid result
// through the window walk with four limb products per stored entry, then 96
// shared multiplier products for the fit terms and, for a positive denominator,
// two bit-serial divisions.
// With fewer than three entries no fit runs; an invalid result goes to the hold state.
// The sample stores need no clearing: only written entries are read.
// A finished result waits in the output register; a new request is taken
// meanwhile, and its result waits until the output register is free.
module clock_drift_linear_fit #(
  parameter int DEPTH = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cdlf_pkg::TickW-1:0]        tick_value_i,
  input  logic [cdlf_pkg::RefW-1:0]         reference_us_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [cdlf_pkg::ResW-1:0]  fit_slope_o,
  output logic signed [cdlf_pkg::ResW-1:0]  fit_offset_o,
  output logic [cdlf_pkg::ExtW-1:0]         anchor_tick_o,
  output logic                              fit_valid_o
);
  import cdlf_pkg::*;

  localparam int CntW = $clog2(DEPTH+1);
  localparam int AW   = $clog2(DEPTH);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_BUSY = 3'b010,
    T_HOLD = 3'b100
  } tstate_e;

  tstate_e                 state_q;
  logic                    accept;
  logic [TickW-1:0]        prev_q;
  logic [WrapW-1:0]        wrap_q, wrap_d;
  logic [ExtW-1:0]         ext_d, ext_q;
  logic signed [DiffW-1:0] diff_d, diff_q;
  logic [AW-1:0]           slot_q;
  logic [CntW-1:0]         filled_q, filled_d, n_q;
  logic                    walk_go_q;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [ExtW-1:0]         rd_tick;
  logic [DiffW-1:0]        rd_diff;
  logic                    win_done, sol_done;
  sums_t                   sums;
  fit_t                    sol_fit, res_q;
  logic                    out_load;
  logic                    out_valid_q;
  logic signed [ResW-1:0]  slope_q, offset_q;
  logic [ExtW-1:0]         anchor_q;
  logic                    fvalid_q;

  assign in_ready_o = (state_q == T_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Extend the tick past 32-bit wraps and form the difference
  assign wrap_d   = (tick_value_i < prev_q) ? wrap_q + WrapW'(1) : wrap_q;
  assign ext_d    = {wrap_d, tick_value_i};
  assign diff_d   = $signed(DiffW'(reference_us_i)) - $signed(DiffW'(ext_d));
  assign filled_d = (filled_q < CntW'(DEPTH)) ? filled_q + CntW'(1) : filled_q;

  // Sample stores, written on accept and read only after that write lands
  cdlf_ram #(.Width(ExtW), .Depth(DEPTH)) u_tick_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (slot_q),
    .wdata_i (ext_d),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_tick)
  );

  cdlf_ram #(.Width(DiffW), .Depth(DEPTH)) u_diff_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (slot_q),
    .wdata_i (diff_d),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_diff)
  );

  cdlf_window #(.DEPTH(DEPTH)) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (walk_go_q),
    .count_i       (n_q),
    .ext_i         (ext_q),
    .anchor_diff_i (diff_q),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_tick_i     (rd_tick),
    .rd_diff_i     (rd_diff),
    .done_o        (win_done),
    .sums_o        (sums)
  );

  cdlf_solver #(.DEPTH(DEPTH)) u_solver (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (win_done),
    .count_i       (n_q),
    .sums_i        (sums),
    .anchor_diff_i (diff_q),
    .done_o        (sol_done),
    .fit_o         (sol_fit)
  );

  assign out_load = (state_q == T_HOLD) && (!out_valid_q || out_ready_i);

  // Sequencing and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      prev_q      <= '0;
      wrap_q      <= '0;
      slot_q      <= '0;
      filled_q    <= '0;
      walk_go_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      walk_go_q <= 1'b0;
      unique case (state_q)
        T_IDLE: if (accept) begin
          prev_q   <= tick_value_i;
          wrap_q   <= wrap_d;
          slot_q   <= (slot_q == AW'(DEPTH-1)) ? '0 : slot_q + AW'(1);
          filled_q <= filled_d;
          if (filled_d < CntW'(MinSamples)) begin
            state_q <= T_HOLD;
          end else begin
            state_q   <= T_BUSY;
            walk_go_q <= 1'b1;
          end
        end
        T_BUSY: if (sol_done) state_q <= T_HOLD;
        T_HOLD: if (out_load) state_q <= T_IDLE;
        default: state_q <= T_IDLE;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request payload and result staging
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ext_q  <= ext_d;
      diff_q <= diff_d;
      n_q    <= filled_d;
      res_q  <= '0;
    end
    if (state_q == T_BUSY && sol_done) begin
      res_q <= sol_fit;
    end
    if (out_load) begin
      slope_q  <= res_q.slope;
      offset_q <= res_q.offset;
      fvalid_q <= res_q.valid;
      anchor_q <= ext_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fit_slope_o   = slope_q;
  assign fit_offset_o  = offset_q;
  assign anchor_tick_o = anchor_q;
  assign fit_valid_o   = fvalid_q;

endmodule

// ===== src/cdlf_checker.sv =====
// Port-level checks of the clock drift fit block, bound to the top level.
// Uses only the top-level ports.
module cdlf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [cdlf_pkg::TickW-1:0]        tick_value_i,
  input logic [cdlf_pkg::RefW-1:0]         reference_us_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [cdlf_pkg::ResW-1:0]  fit_slope_o,
  input logic signed [cdlf_pkg::ResW-1:0]  fit_offset_o,
  input logic [cdlf_pkg::ExtW-1:0]         anchor_tick_o,
  input logic                              fit_valid_o
);

  // A waiting request holds its payload until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(tick_value_i) &&
    $stable(reference_us_i))
    else $error("request changed while waiting");

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fit_slope_o) &&
    $stable(fit_offset_o) && $stable(anchor_tick_o) && $stable(fit_valid_o))
    else $error("result changed while stalled");

  // One request at a time: ready drops after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // An invalid fit reports zero slope and offset
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fit_valid_o |-> fit_slope_o == '0 && fit_offset_o == '0)
    else $error("invalid fit with nonzero terms");

endmodule

bind clock_drift_linear_fit cdlf_checker u_cdlf_checker (.*);
